[rtl/cew_pkg.sv]
// ----------------------------------------------------------------------------
// cew_pkg: shared widths, types and constants of the cotangent edge weight
// Number formats of every pipeline quantity, the sine floor reset value and
// the limits that the weight saturates to.
// ----------------------------------------------------------------------------
package cew_pkg;

  localparam int COORD_W  = 32;   // Q15.16 coordinate
  localparam int DIFF_W   = 33;   // Q16.16 edge vector component
  localparam int PROD_W   = 66;   // product of two components, 32 fraction bits
  localparam int DOT_W    = 67;   // sum of three products
  localparam int CMAG_W   = 65;   // magnitude of one cross component
  localparam int HALF_W   = 32;   // low part of a split cross magnitude
  localparam int SQ_W     = 130;  // square of one cross component
  localparam int LEN2_W   = 132;  // squared cross length
  localparam int ROOT_W   = 66;   // sine, Q.32
  localparam int FRAC_W   = 16;   // fraction bits of the result
  localparam int NUM_W    = 82;   // |cosine| scaled by 2^16
  localparam int COT_W    = 83;   // signed cotangent, Q.16
  localparam int SUM_W    = 84;   // sum of both cotangents
  localparam int FLOOR_W  = 32;
  localparam int WEIGHT_W = 32;

  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = NUM_W;

  // About 1.0e-6 in Q0.32.
  localparam logic [FLOOR_W-1:0] SINE_FLOOR_RESET = 32'd4295;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 32'h7fff_ffff;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 32'h8000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic        [CMAG_W-1:0]  cmag_t;
  typedef logic        [NUM_W-1:0]   num_t;
  typedef logic        [ROOT_W-1:0]  root_t;
  typedef logic        [LEN2_W-1:0]  len2_t;

  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic cmag_t cross_mag(input prod_t c);
    prod_t m;
    m = c[PROD_W-1] ? -c : c;
    return m[CMAG_W-1:0];
  endfunction

endpackage

[rtl/cotangent_edge_weight.sv]
// ----------------------------------------------------------------------------
// cotangent_edge_weight: cotangent Laplacian weight of one interior mesh edge
// Fully pipelined fixed-point datapath: edge vectors, dot and cross products,
// bit-per-stage square root, bit-per-stage division and saturating output.
// ----------------------------------------------------------------------------
// One transaction carries the edge end points and the two opposite apexes;
// each yields one weight = floor((cot_a + cot_b) / 2) in Q15.16, clamped to
// 32 bits with saturated flagging the clamp. A new transaction is taken in
// every cycle while in_stall is low; from acceptance to out_valid it passes
// 7 arithmetic stages, 66 square-root stages (one root bit each), one divisor
// select stage, 82 divider stages (one quotient bit each), a sign stage and
// the output register. The whole pipeline advances together; it holds only
// while a result sits in the output register and out_stall is high, and
// in_stall then follows out_stall in the same cycle. sine_floor (Q0.32) is
// written through the cfg channel, which is always ready; write it only while
// no transaction is in flight. A floor of zero acts as one unit.
// ----------------------------------------------------------------------------
module cotangent_edge_weight import cew_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  edge_start_x,
  input  logic signed [31:0]  edge_start_y,
  input  logic signed [31:0]  edge_start_z,
  input  logic signed [31:0]  edge_end_x,
  input  logic signed [31:0]  edge_end_y,
  input  logic signed [31:0]  edge_end_z,
  input  logic signed [31:0]  apex_a_x,
  input  logic signed [31:0]  apex_a_y,
  input  logic signed [31:0]  apex_a_z,
  input  logic signed [31:0]  apex_b_x,
  input  logic signed [31:0]  apex_b_y,
  input  logic signed [31:0]  apex_b_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  weight,
  output logic                saturated,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  // Advance every stage unless a finished result is held by the receiver.
  logic adv;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  logic [FLOOR_W-1:0] sine_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_floor <= SINE_FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sine_floor <= cfg_data;
    end
  end

  // Gather the points; apex index 0 is A, 1 is B.
  coord_t e0 [3];
  coord_t e1 [3];
  coord_t ap [2][3];

  assign e0[0] = edge_start_x;
  assign e0[1] = edge_start_y;
  assign e0[2] = edge_start_z;
  assign e1[0] = edge_end_x;
  assign e1[1] = edge_end_y;
  assign e1[2] = edge_end_z;
  assign ap[0][0] = apex_a_x;
  assign ap[0][1] = apex_a_y;
  assign ap[0][2] = apex_a_z;
  assign ap[1][0] = apex_b_x;
  assign ap[1][1] = apex_b_y;
  assign ap[1][2] = apex_b_z;

  // Stage 1: edge vectors u = E0 - P and v = E1 - P, exact in 33 bits.
  logic  s1_vld;
  diff_t s1_u [2][3];
  diff_t s1_v [2][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s1_u[a][i] <= coord_diff(e0[i], ap[a][i]);
          s1_v[a][i] <= coord_diff(e1[i], ap[a][i]);
        end
      end
    end
  end

  // Stage 2: the three dot terms and the six cross terms, one 33x33 each.
  logic  s2_vld;
  prod_t s2_dot [2][3];
  prod_t s2_cr  [2][6];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s2_dot[a][i] <= s1_u[a][i] * s1_v[a][i];
        end
        s2_cr[a][0] <= s1_u[a][1] * s1_v[a][2];
        s2_cr[a][1] <= s1_u[a][2] * s1_v[a][1];
        s2_cr[a][2] <= s1_u[a][2] * s1_v[a][0];
        s2_cr[a][3] <= s1_u[a][0] * s1_v[a][2];
        s2_cr[a][4] <= s1_u[a][0] * s1_v[a][1];
        s2_cr[a][5] <= s1_u[a][1] * s1_v[a][0];
      end
    end
  end

  // Stage 3: cross components and the cosine (dot product).
  logic  s3_vld;
  prod_t s3_cr  [2][3];
  dot_t  s3_dot [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s3_cr[a][i] <= s2_cr[a][2*i] - s2_cr[a][2*i+1];
        end
        s3_dot[a] <= dot_t'(s2_dot[a][0]) + dot_t'(s2_dot[a][1]) + dot_t'(s2_dot[a][2]);
      end
    end
  end

  // Stage 4: magnitudes; keep the cosine as sign and scaled magnitude.
  logic  s4_vld;
  cmag_t s4_cm  [2][3];
  logic  s4_neg [2];
  num_t  s4_num [2];
  dot_t  dot_abs [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dot_abs[a] = s3_dot[a][DOT_W-1] ? -s3_dot[a] : s3_dot[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s4_cm[a][i] <= cross_mag(s3_cr[a][i]);
        end
        s4_neg[a] <= s3_dot[a][DOT_W-1];
        s4_num[a] <= {dot_abs[a][DOT_W-2:0], {FRAC_W{1'b0}}};
      end
    end
  end

  // Stage 5: square each cross magnitude as high/low partial products.
  logic                          s5_vld;
  logic [2*(CMAG_W-HALF_W)-1:0]  s5_hh [2][3];
  logic [CMAG_W-1:0]             s5_hl [2][3];
  logic [2*HALF_W-1:0]           s5_ll [2][3];
  logic                          s5_neg [2];
  num_t                          s5_num [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (adv) begin
      s5_vld <= s4_vld;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s5_hh[a][i] <= s4_cm[a][i][CMAG_W-1:HALF_W] * s4_cm[a][i][CMAG_W-1:HALF_W];
          s5_hl[a][i] <= s4_cm[a][i][CMAG_W-1:HALF_W] * s4_cm[a][i][HALF_W-1:0];
          s5_ll[a][i] <= s4_cm[a][i][HALF_W-1:0] * s4_cm[a][i][HALF_W-1:0];
        end
        s5_neg[a] <= s4_neg[a];
        s5_num[a] <= s4_num[a];
      end
    end
  end

  // Stage 6: recombine each square (the cross term counts twice).
  logic            s6_vld;
  logic [SQ_W-1:0] s6_sq [2][3];
  logic            s6_neg [2];
  num_t            s6_num [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (adv) begin
      s6_vld <= s5_vld;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s6_sq[a][i] <= {s5_hh[a][i], {(2*HALF_W){1'b0}}}
                       + {{(SQ_W-CMAG_W-HALF_W-1){1'b0}}, s5_hl[a][i], {(HALF_W+1){1'b0}}}
                       + {{(SQ_W-2*HALF_W){1'b0}}, s5_ll[a][i]};
        end
        s6_neg[a] <= s5_neg[a];
        s6_num[a] <= s5_num[a];
      end
    end
  end

  // Stage 7: squared cross length.
  logic  s7_vld;
  len2_t s7_len2 [2];
  logic  s7_neg [2];
  num_t  s7_num [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (adv) begin
      s7_vld <= s6_vld;
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        s7_len2[a] <= {2'b00, s6_sq[a][0]} + {2'b00, s6_sq[a][1]} + {2'b00, s6_sq[a][2]};
        s7_neg[a]  <= s6_neg[a];
        s7_num[a]  <= s6_num[a];
      end
    end
  end

  // Square root: one root bit per stage, MSB first. rem holds n - root^2.
  logic  sr_vld  [1:SQRT_STEPS];
  root_t sr_root [1:SQRT_STEPS][2];
  len2_t sr_rem  [1:SQRT_STEPS][2];
  logic  sr_neg  [1:SQRT_STEPS][2];
  num_t  sr_num  [1:SQRT_STEPS][2];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic                vld_in;
    root_t               root_in [2];
    len2_t               rem_in  [2];
    logic                neg_in  [2];
    num_t                num_in  [2];
    logic [LEN2_W+1:0]   trial   [2];
    logic                take    [2];

    if (k == 0) begin : g_head
      always_comb begin
        vld_in = s7_vld;
        for (int a = 0; a < 2; a++) begin
          root_in[a] = '0;
          rem_in[a]  = s7_len2[a];
          neg_in[a]  = s7_neg[a];
          num_in[a]  = s7_num[a];
        end
      end
    end else begin : g_body
      always_comb begin
        vld_in = sr_vld[k];
        for (int a = 0; a < 2; a++) begin
          root_in[a] = sr_root[k][a];
          rem_in[a]  = sr_rem[k][a];
          neg_in[a]  = sr_neg[k][a];
          num_in[a]  = sr_num[k][a];
        end
      end
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    always_comb begin
      for (int a = 0; a < 2; a++) begin
        trial[a] = ({{(LEN2_W+2-ROOT_W){1'b0}}, root_in[a]} << (B + 1))
                 | ((LEN2_W+2)'(1) << (2 * B));
        take[a]  = {2'b00, rem_in[a]} >= trial[a];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sr_vld[k+1] <= vld_in;
      end
      if (adv) begin
        for (int a = 0; a < 2; a++) begin
          sr_root[k+1][a] <= take[a] ? (root_in[a] | (ROOT_W'(1) << B)) : root_in[a];
          sr_rem[k+1][a]  <= take[a] ? (rem_in[a] - trial[a][LEN2_W-1:0]) : rem_in[a];
          sr_neg[k+1][a]  <= neg_in[a];
          sr_num[k+1][a]  <= num_in[a];
        end
      end
    end
  end

  // Divisor: the sine raised to the floor; a zero floor counts as one unit.
  logic  d_vld;
  root_t d_den [2];
  logic  d_neg [2];
  num_t  d_num [2];
  root_t floor_eff;

  assign floor_eff = {{(ROOT_W-FLOOR_W){1'b0}},
                      (sine_floor == '0) ? FLOOR_W'(1) : sine_floor};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (adv) begin
      d_vld <= sr_vld[SQRT_STEPS];
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        d_den[a] <= (sr_root[SQRT_STEPS][a] > floor_eff) ? sr_root[SQRT_STEPS][a] : floor_eff;
        d_neg[a] <= sr_neg[SQRT_STEPS][a];
        d_num[a] <= sr_num[SQRT_STEPS][a];
      end
    end
  end

  // Restoring divider, one quotient bit per stage. nq shifts the dividend
  // out at the top while the quotient shifts in at the bottom.
  logic  dv_vld [1:DIV_STEPS];
  num_t  dv_nq  [1:DIV_STEPS][2];
  root_t dv_rem [1:DIV_STEPS][2];
  root_t dv_den [1:DIV_STEPS][2];
  logic  dv_neg [1:DIV_STEPS][2];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic            vld_in;
    num_t            nq_in  [2];
    root_t           rem_in [2];
    root_t           den_in [2];
    logic            neg_in [2];
    logic [ROOT_W:0] trial  [2];
    logic [ROOT_W:0] diff   [2];
    logic            take   [2];

    if (k == 0) begin : g_head
      always_comb begin
        vld_in = d_vld;
        for (int a = 0; a < 2; a++) begin
          nq_in[a]  = d_num[a];
          rem_in[a] = '0;
          den_in[a] = d_den[a];
          neg_in[a] = d_neg[a];
        end
      end
    end else begin : g_body
      always_comb begin
        vld_in = dv_vld[k];
        for (int a = 0; a < 2; a++) begin
          nq_in[a]  = dv_nq[k][a];
          rem_in[a] = dv_rem[k][a];
          den_in[a] = dv_den[k][a];
          neg_in[a] = dv_neg[k][a];
        end
      end
    end

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        trial[a] = {rem_in[a], nq_in[a][NUM_W-1]};
        diff[a]  = trial[a] - {1'b0, den_in[a]};
        take[a]  = trial[a] >= {1'b0, den_in[a]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[k+1] <= vld_in;
      end
      if (adv) begin
        for (int a = 0; a < 2; a++) begin
          dv_nq[k+1][a]  <= {nq_in[a][NUM_W-2:0], take[a]};
          dv_rem[k+1][a] <= take[a] ? diff[a][ROOT_W-1:0] : trial[a][ROOT_W-1:0];
          dv_den[k+1][a] <= den_in[a];
          dv_neg[k+1][a] <= neg_in[a];
        end
      end
    end
  end

  // Sign stage: restore the cosine sign (quotient truncated toward zero).
  logic                    f_vld;
  logic signed [COT_W-1:0] f_cot [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= dv_vld[DIV_STEPS];
    end
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        f_cot[a] <= dv_neg[DIV_STEPS][a] ? -$signed({1'b0, dv_nq[DIV_STEPS][a]})
                                         : $signed({1'b0, dv_nq[DIV_STEPS][a]});
      end
    end
  end

  // Output register: halve the sum with floor, then clamp to 32 bits.
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-2:0]        half;
  logic                    fits;

  always_comb begin
    sum  = SUM_W'(f_cot[0]) + SUM_W'(f_cot[1]);
    half = sum[SUM_W-1:1];
    fits = (&half[SUM_W-2:WEIGHT_W-1]) || !(|half[SUM_W-2:WEIGHT_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_vld;
    end
    if (adv) begin
      if (fits) begin
        weight <= half[WEIGHT_W-1:0];
      end else begin
        weight <= half[SUM_W-2] ? WEIGHT_MIN : WEIGHT_MAX;
      end
      saturated <= !fits;
    end
  end

endmodule

[rtl/cew_checker.sv]
// ----------------------------------------------------------------------------
// cew_checker: port-level checks of the cotangent edge weight
// Watches the handshakes and the result of the top level and is bound to it.
// ----------------------------------------------------------------------------
module cew_checker import cew_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] weight,
  input logic               saturated,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight) && $stable(saturated))
    else $error("stalled result changed or dropped");

  // Stall the input only while the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // Drop all results at reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A clamped weight sits at one of the range limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> weight == WEIGHT_MAX || weight == WEIGHT_MIN)
    else $error("saturated weight not at a limit");

  // Take every register write at once.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write held off");

endmodule

bind cotangent_edge_weight cew_checker u_cew_checker (.*);
